FILE: src/tws_pkg.sv
// tws_pkg: shared types and constants for the three-wire serial master
// depends on nothing; used by every module under src
package tws_pkg;

    // data bytes a transaction can carry
    localparam int MAX_BYTES = 7;

    // field widths fixed by the link
    localparam int HALF_W    = 16;
    localparam int CMD_W     = 8;
    localparam int COUNT_W   = 3;
    localparam int DATA_W    = 56;

    // stream widths
    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 64;

    // reset value of the half period register
    localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(10);

    // default depth of the queue between front and engine
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_CMD_LOW   = 3'd1,
        PH_CMD_HIGH  = 3'd2,
        PH_DATA_LOW  = 3'd3,
        PH_DATA_HIGH = 3'd4,
        PH_TAIL      = 3'd5
    } phase_t;

    // one classified tick request
    typedef struct packed {
        logic                start;
        logic                is_write;
        logic [CMD_W-1:0]    command;
        logic [COUNT_W-1:0]  bytes_total;
        logic [DATA_W-1:0]   write_data;
        logic                sio_in;
    } tws_req_t;

endpackage

FILE: src/three_wire_serial_master.sv
// three_wire_serial_master: top level of the tick-driven three-wire serial master
// depends on tws_pkg, tws_front, tws_queue, tws_engine
//
// Each request on the slave stream is one timing tick of the serial link and
// produces exactly one response on the master stream carrying the pin levels
// after that tick (chip select, serial clock, data out and drive enable) plus
// busy, a one-tick done pulse and the bytes read. A tick with start set while
// idle opens a transaction: chip select rises, the command byte goes out MSB
// first, then 1 to 7 data bytes are written or read LSB first. Each bit is a
// low half then a high half of half_period_ticks ticks each (0 acts as 1);
// read bits are sampled on the tick that ends the high half. The block takes
// one request per clock cycle while the queue has space: the front unpacks
// and classifies the request into a QUEUE_DEPTH-entry queue, and the engine
// retires one queued tick per cycle into the output register whenever that
// register is empty or being taken; a request waits in the queue, then in
// the output register. The half period register is written through cfg_we
// and cfg_wdata and should only change while the link is idle.
module three_wire_serial_master
#(
    parameter int QUEUE_DEPTH = tws_pkg::QUEUE_DEPTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // half period register write
    input  logic                          cfg_we,
    input  logic [tws_pkg::HALF_W-1:0]    cfg_wdata,
    // tick request stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // command [7:0], byte_count [10:8], write_data [66:11], sio_in [67], zero pad
    input  logic [tws_pkg::S_TDATA_W-1:0] s_tdata,
    // start_req [0], is_write [1]
    input  logic [tws_pkg::S_TUSER_W-1:0] s_tuser,
    // tick response stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // chip_select [0], serial_clock [1], sio_out [2], sio_drive [3],
    // busy_res [4], done_res [5], read_data [61:6], zero pad
    output logic [tws_pkg::M_TDATA_W-1:0] m_tdata
);

    tws_pkg::tws_req_t front_req;
    tws_pkg::tws_req_t queue_req;
    logic              q_full;
    logic              q_empty;
    logic              q_push;
    logic              q_pop;

    // queue space decides acceptance
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    tws_front u_front
    (
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .req     (front_req)
    );

    tws_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_req (front_req),
        .pop      (q_pop),
        .pop_req  (queue_req),
        .full     (q_full),
        .empty    (q_empty)
    );

    // serial engine with its output register
    tws_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (!q_empty),
        .req       (queue_req),
        .req_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: src/tws_front.sv
// tws_front: unpacks a stream request and classifies it for the engine
// depends on tws_pkg
module tws_front
(
    input  logic [tws_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [tws_pkg::S_TUSER_W-1:0] s_tuser,
    output tws_pkg::tws_req_t             req
);

    logic [tws_pkg::COUNT_W-1:0] count_raw;
    logic                        is_write;

    assign count_raw = s_tdata[10:8];
    assign is_write  = s_tuser[1];

    always_comb
    begin
        req.start    = s_tuser[0];
        req.is_write = is_write;
        req.command  = s_tdata[7:0];
        req.sio_in   = s_tdata[67];
        // write data only matters on a write, reads start from zero
        req.write_data = is_write ? s_tdata[66:11] : '0;
        // zero count acts as one, large count saturates
        if (count_raw == '0)
        begin
            req.bytes_total = tws_pkg::COUNT_W'(1);
        end
        else if ({1'b0, count_raw} > (tws_pkg::COUNT_W+1)'(tws_pkg::MAX_BYTES))
        begin
            req.bytes_total = tws_pkg::COUNT_W'(tws_pkg::MAX_BYTES);
        end
        else
        begin
            req.bytes_total = count_raw;
        end
    end

endmodule

FILE: src/tws_queue.sv
// tws_queue: short request fifo between the front and the serial engine
// depends on tws_pkg
module tws_queue
#(
    parameter int DEPTH = tws_pkg::QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tws_pkg::tws_req_t push_req,
    input  logic              pop,
    output tws_pkg::tws_req_t pop_req,
    output logic              full,
    output logic              empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tws_pkg::tws_req_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_req = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_req;
        end
    end

endmodule

FILE: src/tws_engine.sv
// tws_engine: serial link state machine, one tick per request, plus output register
// depends on tws_pkg
module tws_engine
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tws_pkg::HALF_W-1:0]    cfg_wdata,
    input  logic                          req_valid,
    input  tws_pkg::tws_req_t             req,
    output logic                          req_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tws_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int HW = tws_pkg::HALF_W;
    localparam int DW = tws_pkg::DATA_W;

    logic [HW-1:0]              half_period_reg;
    tws_pkg::phase_t            phase_reg, phase_next;
    logic [HW-1:0]              half_cnt_reg, half_cnt_next;
    logic [2:0]                 bit_idx_reg, bit_idx_next;
    logic [2:0]                 byte_idx_reg, byte_idx_next;
    logic [tws_pkg::CMD_W-1:0]  cmd_shift_reg, cmd_shift_next;
    logic [DW-1:0]              data_shift_reg, data_shift_next;
    logic [tws_pkg::COUNT_W-1:0] bytes_total_reg, bytes_total_next;
    logic                       write_mode_reg, write_mode_next;
    logic                       m_valid_reg;
    logic [tws_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic [HW-1:0] half_eff;
    logic          half_over;
    logic          done;
    logic [DW-1:0] rdata;
    logic [63:0]   shift_ext;
    logic [5:0]    pos_cur;
    logic [5:0]    pos_next;
    logic          cs, sclk, sout, drive;

    assign req_pop  = req_valid && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign half_eff  = (half_period_reg == '0) ? HW'(1) : half_period_reg;
    assign half_over = (half_cnt_reg >= half_eff);
    assign pos_cur   = {byte_idx_reg, bit_idx_reg};

    // next state of one tick
    always_comb
    begin
        phase_next       = phase_reg;
        half_cnt_next    = half_over ? half_cnt_reg : half_cnt_reg + 1'b1;
        bit_idx_next     = bit_idx_reg;
        byte_idx_next    = byte_idx_reg;
        cmd_shift_next   = cmd_shift_reg;
        data_shift_next  = data_shift_reg;
        bytes_total_next = bytes_total_reg;
        write_mode_next  = write_mode_reg;
        done             = 1'b0;
        rdata            = '0;
        shift_ext        = {8'b0, data_shift_reg};

        case (phase_reg)
            tws_pkg::PH_CMD_LOW:
            begin
                if (half_over)
                begin
                    phase_next    = tws_pkg::PH_CMD_HIGH;
                    half_cnt_next = HW'(1);
                end
            end
            tws_pkg::PH_CMD_HIGH:
            begin
                if (half_over)
                begin
                    half_cnt_next = HW'(1);
                    if (bit_idx_reg == '0)
                    begin
                        phase_next    = tws_pkg::PH_DATA_LOW;
                        bit_idx_next  = '0;
                        byte_idx_next = '0;
                    end
                    else
                    begin
                        bit_idx_next = bit_idx_reg - 1'b1;
                        phase_next   = tws_pkg::PH_CMD_LOW;
                    end
                end
            end
            tws_pkg::PH_DATA_LOW:
            begin
                if (half_over)
                begin
                    phase_next    = tws_pkg::PH_DATA_HIGH;
                    half_cnt_next = HW'(1);
                end
            end
            tws_pkg::PH_DATA_HIGH:
            begin
                if (half_over)
                begin
                    half_cnt_next = HW'(1);
                    if (!write_mode_reg)
                    begin
                        shift_ext[pos_cur] = shift_ext[pos_cur] | req.sio_in;
                        data_shift_next    = shift_ext[DW-1:0];
                    end
                    if (bit_idx_reg == 3'd7)
                    begin
                        if ({1'b0, byte_idx_reg} + 4'd1 >= {1'b0, bytes_total_reg})
                        begin
                            phase_next = tws_pkg::PH_TAIL;
                        end
                        else
                        begin
                            byte_idx_next = byte_idx_reg + 1'b1;
                            bit_idx_next  = '0;
                            phase_next    = tws_pkg::PH_DATA_LOW;
                        end
                    end
                    else
                    begin
                        bit_idx_next = bit_idx_reg + 1'b1;
                        phase_next   = tws_pkg::PH_DATA_LOW;
                    end
                end
            end
            tws_pkg::PH_TAIL:
            begin
                if (half_over)
                begin
                    phase_next    = tws_pkg::PH_IDLE;
                    half_cnt_next = '0;
                    done          = 1'b1;
                    if (!write_mode_reg)
                    begin
                        rdata = data_shift_reg;
                    end
                end
            end
            default:
            begin
                phase_next    = tws_pkg::PH_IDLE;
                half_cnt_next = '0;
                if (req.start)
                begin
                    bytes_total_next = req.bytes_total;
                    write_mode_next  = req.is_write;
                    cmd_shift_next   = req.command;
                    data_shift_next  = req.write_data;
                    bit_idx_next     = 3'd7;
                    byte_idx_next    = '0;
                    half_cnt_next    = HW'(1);
                    phase_next       = tws_pkg::PH_CMD_LOW;
                end
            end
        endcase
    end

    // pin levels after the tick
    always_comb
    begin
        pos_next = {byte_idx_next, bit_idx_next};
        cs       = phase_next inside {tws_pkg::PH_CMD_LOW, tws_pkg::PH_CMD_HIGH,
                                      tws_pkg::PH_DATA_LOW, tws_pkg::PH_DATA_HIGH};
        sclk     = !(phase_next inside {tws_pkg::PH_CMD_LOW, tws_pkg::PH_DATA_LOW});
        drive    = 1'b0;
        sout     = 1'b0;
        if (phase_next inside {tws_pkg::PH_CMD_LOW, tws_pkg::PH_CMD_HIGH})
        begin
            drive = 1'b1;
            sout  = cmd_shift_next[bit_idx_next];
        end
        else if ((phase_next inside {tws_pkg::PH_DATA_LOW, tws_pkg::PH_DATA_HIGH})
                 && write_mode_next)
        begin
            drive = 1'b1;
            sout  = data_shift_next[pos_next];
        end
        m_data_next = {2'b00, rdata, done, (phase_next != tws_pkg::PH_IDLE),
                       drive, sout, sclk, cs};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= tws_pkg::HALF_RESET;
            phase_reg       <= tws_pkg::PH_IDLE;
            half_cnt_reg    <= '0;
            bit_idx_reg     <= '0;
            byte_idx_reg    <= '0;
            cmd_shift_reg   <= '0;
            data_shift_reg  <= '0;
            bytes_total_reg <= '0;
            write_mode_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                half_period_reg <= cfg_wdata;
            end
            if (req_pop)
            begin
                phase_reg       <= phase_next;
                half_cnt_reg    <= half_cnt_next;
                bit_idx_reg     <= bit_idx_next;
                byte_idx_reg    <= byte_idx_next;
                cmd_shift_reg   <= cmd_shift_next;
                data_shift_reg  <= data_shift_next;
                bytes_total_reg <= bytes_total_next;
                write_mode_reg  <= write_mode_next;
                m_valid_reg     <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_pop)
        begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

FILE: tb/sv/tws_link_checker.sv
// tws_link_checker: tick-by-tick predictor and response checker for the serial master
// depends on tws_pkg; instantiated beside the block by tb_three_wire_serial_master
module tws_link_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tws_pkg::HALF_W-1:0]    cfg_wdata,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [tws_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [tws_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [tws_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            fail_count,
    output int                            pending,
    output int                            done_count
);
    import tws_pkg::*;

    // response layout, chip select in bit 0
    typedef struct packed {
        logic [1:0]        pad;
        logic [DATA_W-1:0] read_data;
        logic              done;
        logic              busy;
        logic              drive;
        logic              sout;
        logic              sclk;
        logic              cs;
    } pin_levels_t;

    pin_levels_t       levels_q[$];

    // own copy of the link state and the half period register
    phase_t            link_phase;
    logic [HALF_W-1:0] half_cfg;
    logic [HALF_W-1:0] half_cnt;
    logic [2:0]        bit_idx;
    logic [2:0]        byte_idx;
    logic [CMD_W-1:0]  cmd_reg;
    logic [DATA_W-1:0] data_reg;
    logic [2:0]        nbytes;
    logic              wr_mode;

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // advance the link by one tick and return the pin levels after it
    task automatic step_link(input logic [S_TDATA_W-1:0] data,
                             input logic [S_TUSER_W-1:0] user, output pin_levels_t want);
        logic [HALF_W-1:0] h_eff;
        logic              over;
        logic [5:0]        pos;
        logic [2:0]        n;
        want  = '0;
        h_eff = (half_cfg == '0) ? HALF_W'(1) : half_cfg;
        over  = (half_cnt >= h_eff);
        if (!over)
            half_cnt = half_cnt + 1'b1;
        case (link_phase)
            PH_CMD_LOW:
                if (over)
                begin
                    link_phase = PH_CMD_HIGH;
                    half_cnt   = HALF_W'(1);
                end
            PH_CMD_HIGH:
                if (over)
                begin
                    half_cnt = HALF_W'(1);
                    if (bit_idx == 3'd0)
                    begin
                        link_phase = PH_DATA_LOW;
                        byte_idx   = 3'd0;
                    end
                    else
                    begin
                        bit_idx    = bit_idx - 1'b1;
                        link_phase = PH_CMD_LOW;
                    end
                end
            PH_DATA_LOW:
                if (over)
                begin
                    link_phase = PH_DATA_HIGH;
                    half_cnt   = HALF_W'(1);
                end
            PH_DATA_HIGH:
                if (over)
                begin
                    half_cnt = HALF_W'(1);
                    pos      = {byte_idx, bit_idx};
                    // read bit taken at the end of the high half
                    if (!wr_mode)
                        data_reg[pos] = data_reg[pos] | data[67];
                    if (bit_idx == 3'd7)
                    begin
                        if ({1'b0, byte_idx} + 4'd1 >= {1'b0, nbytes})
                            link_phase = PH_TAIL;
                        else
                        begin
                            byte_idx   = byte_idx + 1'b1;
                            bit_idx    = 3'd0;
                            link_phase = PH_DATA_LOW;
                        end
                    end
                    else
                    begin
                        bit_idx    = bit_idx + 1'b1;
                        link_phase = PH_DATA_LOW;
                    end
                end
            PH_TAIL:
                if (over)
                begin
                    link_phase     = PH_IDLE;
                    half_cnt       = '0;
                    want.done      = 1'b1;
                    want.read_data = wr_mode ? '0 : data_reg;
                end
            default:
            begin
                link_phase = PH_IDLE;
                half_cnt   = '0;
                if (user[0])
                begin
                    n          = data[10:8];
                    nbytes     = (n == 3'd0) ? 3'd1 : n;
                    wr_mode    = user[1];
                    cmd_reg    = data[7:0];
                    data_reg   = user[1] ? data[66:11] : '0;
                    bit_idx    = 3'd7;
                    byte_idx   = 3'd0;
                    half_cnt   = HALF_W'(1);
                    link_phase = PH_CMD_LOW;
                end
            end
        endcase

        pos       = {byte_idx, bit_idx};
        want.cs   = (link_phase == PH_CMD_LOW) || (link_phase == PH_CMD_HIGH) ||
                    (link_phase == PH_DATA_LOW) || (link_phase == PH_DATA_HIGH);
        want.sclk = !((link_phase == PH_CMD_LOW) || (link_phase == PH_DATA_LOW));
        want.busy = (link_phase != PH_IDLE);
        if ((link_phase == PH_CMD_LOW) || (link_phase == PH_CMD_HIGH))
        begin
            want.drive = 1'b1;
            want.sout  = cmd_reg[bit_idx];
        end
        else if (((link_phase == PH_DATA_LOW) || (link_phase == PH_DATA_HIGH)) && wr_mode)
        begin
            want.drive = 1'b1;
            want.sout  = data_reg[pos];
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pin_levels_t want;
        pin_levels_t got;
        if (!rst_n)
        begin
            link_phase = PH_IDLE;
            half_cfg   = HALF_RESET;
            half_cnt   = '0;
            bit_idx    = '0;
            byte_idx   = '0;
            cmd_reg    = '0;
            data_reg   = '0;
            nbytes     = '0;
            wr_mode    = 1'b0;
            levels_q.delete();
            pending    = 0;
            fail_count = 0;
            done_count = 0;
        end
        else
        begin
            if (cfg_we)
                half_cfg = cfg_wdata;
            if (s_tvalid && s_tready)
            begin
                step_link(s_tdata, s_tuser, want);
                levels_q.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (levels_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: response with nothing expected, expected none, actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = levels_q.pop_front();
                    check_field("chip_select", DATA_W'(want.cs), DATA_W'(got.cs));
                    check_field("serial_clock", DATA_W'(want.sclk), DATA_W'(got.sclk));
                    check_field("sio_out", DATA_W'(want.sout), DATA_W'(got.sout));
                    check_field("sio_drive", DATA_W'(want.drive), DATA_W'(got.drive));
                    check_field("busy", DATA_W'(want.busy), DATA_W'(got.busy));
                    check_field("done", DATA_W'(want.done), DATA_W'(got.done));
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("pad", DATA_W'(want.pad), DATA_W'(got.pad));
                    if (want.done)
                        done_count++;
                end
            end
            pending = levels_q.size();
        end
    end

endmodule

FILE: tb/sv/tb_three_wire_serial_master.sv
// tb_three_wire_serial_master: stimulus and verdict for the three-wire serial master
// depends on tws_pkg, three_wire_serial_master and tws_link_checker
module tb_three_wire_serial_master;
    import tws_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [HALF_W-1:0]    cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    // command [7:0], byte_count [10:8], write_data [66:11], sio_in [67], zero pad
    logic [S_TDATA_W-1:0] s_tdata;
    // start_req [0], is_write [1]
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    // chip_select [0], serial_clock [1], sio_out [2], sio_drive [3],
    // busy_res [4], done_res [5], read_data [61:6], zero pad
    logic [M_TDATA_W-1:0] m_tdata;

    int                   fail_count;
    int                   pending;
    int                   done_count;

    // idling knobs, percent of cycles
    int                   send_idle_pct;
    int                   recv_stall_pct;
    // asks the response side for one long hold-off
    bit                   hold_req;

    int                   tick_count;
    int                   start_count;
    // half period currently in the register, used to time whole transfers
    logic [HALF_W-1:0]    half_now;

    three_wire_serial_master dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    tws_link_checker chk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending),
        .done_count (done_count)
    );

    always #2 clk = ~clk;

    // run limit, far above the slowest legal run
    initial
    begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // response side: random stalls, plus one long hold counted here
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = 80;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // one tick request; called and returns at a falling edge
    task automatic send_tick(input logic start, input logic wr, input logic [CMD_W-1:0] cmd,
                             input logic [COUNT_W-1:0] cnt, input logic [DATA_W-1:0] wd,
                             input logic sio);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, sio, wd, cnt, cmd};
        s_tuser  <= {wr, start};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        tick_count++;
    endtask

    // tick with random content; a start here is ignored while a transfer runs
    task automatic filler_tick(input bit may_start);
        logic [63:0] r;
        r = {$urandom, $urandom};
        send_tick(may_start && ($urandom_range(0, 3) == 0), 1'($urandom_range(0, 1)),
                  CMD_W'($urandom_range(0, 255)), COUNT_W'($urandom_range(0, 7)),
                  r[DATA_W-1:0], 1'($urandom_range(0, 1)));
    endtask

    // start request then ticks up to the end of the tail half, one short of the done pulse
    task automatic run_transfer(input logic wr, input logic [CMD_W-1:0] cmd,
                                input logic [COUNT_W-1:0] cnt, input logic [DATA_W-1:0] wd,
                                input int gap);
        int h;
        int n;
        int span;
        h    = (half_now == '0) ? 1 : half_now;
        n    = (cnt == '0) ? 1 : cnt;
        // command 16 halves, data 16 per byte, one tail half; the start tick opens the first
        span = h * (17 + 16 * n) - 1;
        send_tick(1'b1, wr, cmd, cnt, wd, 1'($urandom_range(0, 1)));
        start_count++;
        repeat (span)
            filler_tick(1'b1);
        repeat (gap)
            filler_tick(1'b0);
    endtask

    // register write once every response is back, whether or not the link is idle
    task automatic set_half(input logic [HALF_W-1:0] v);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        half_now  = v;
    endtask

    // mostly whole transfers with random content, some idle noise between
    task automatic random_phase(input int budget);
        int          first;
        logic [63:0] r;
        first = tick_count;
        while (tick_count - first < budget)
        begin
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 6))
                    filler_tick(1'b0);
            else
            begin
                r = {$urandom, $urandom};
                // short transfers dominate, the full byte range still shows up
                run_transfer(1'($urandom_range(0, 1)), CMD_W'($urandom_range(0, 255)),
                             COUNT_W'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 2)
                                                                  : $urandom_range(0, 7)),
                             r[DATA_W-1:0], $urandom_range(0, 3));
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        tick_count     = 0;
        start_count    = 0;
        half_now       = HALF_RESET;
        repeat (7)
            @(negedge clk);
        rst_n = 1'b1;

        // directed: reset half period through one low and one high half
        send_tick(1'b1, 1'b1, 8'h80, 3'd1, 56'h5A, 1'b0);
        start_count++;
        repeat (24)
            filler_tick(1'b0);
        // fastest link for the rest of that transfer, then idle
        set_half(16'd1);
        repeat (40)
            filler_tick(1'b0);

        // longest read, write data ignored on a read
        run_transfer(1'b0, 8'hFF, 3'd7, 56'hFF_FFFF_FFFF_FFFF, 0);
        // byte count zero acts as one; its start tick is the done tick of the read above
        run_transfer(1'b1, 8'hA5, 3'd0, 56'h00_0000_0000_00C3, 1);

        // zero half period behaves as one
        set_half(16'd0);
        run_transfer(1'b1, 8'h7E, 3'd1, 56'h12_3456_789A_BCDE, 1);

        // widest register value, only idle ticks while it holds
        set_half(16'hFFFF);
        repeat (6)
            filler_tick(1'b0);

        // random, no idling; the response side holds off long so the block fills
        set_half(16'd1);
        hold_req = 1'b1;
        random_phase(25);

        // random, request side mostly idle
        set_half(16'd0);
        send_idle_pct = 78;
        random_phase(25);

        // random, response side mostly stalled
        set_half(16'd2);
        send_idle_pct  = 0;
        recv_stall_pct = 78;
        random_phase(25);

        // random, light idling on both sides
        set_half(HALF_W'($urandom_range(1, 2)));
        send_idle_pct  = 12;
        recv_stall_pct = 12;
        random_phase(25);

        // drain and let the output settle
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10)
            @(negedge clk);

        $display("covered %0d ticks, %0d transfer starts, %0d completions checked",
                 tick_count, start_count, done_count);
        $display("half periods from 0 to 65535, reads and writes of 0 to 7 bytes, with stalls");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
src/tws_pkg.sv
src/tws_front.sv
src/tws_queue.sv
src/tws_engine.sv
src/three_wire_serial_master.sv
tb/sv/tws_link_checker.sv
tb/sv/tb_three_wire_serial_master.sv
